@@ rtl/drawbridge_sequence_controller_top_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef DRAWBRIDGE_SEQUENCE_CONTROLLER_TOP_MACROS_SVH
`define DRAWBRIDGE_SEQUENCE_CONTROLLER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dsc_pkg.sv @@
package dsc_pkg;

  localparam int REQ_W  = 3;
  localparam int DIM_W  = 16;
  localparam int TGT_W  = 3;
  localparam int CODE_W = 3;
  localparam int ST_W   = 3;
  localparam int CNT_OUT_W = 5;
  localparam int MAX_CMDS  = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register select values (index in address bit 2)
  localparam logic REG_MAX_HEIGHT = 1'b0;
  localparam logic REG_MAX_WIDTH  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_IDLE               = 3'd0,
    ST_WAIT_ROAD_RED      = 3'd1,
    ST_WAIT_BARRIER_CLOSED = 3'd2,
    ST_WAIT_BRIDGE_OPEN   = 3'd3,
    ST_OPEN               = 3'd4,
    ST_WAIT_BRIDGE_CLOSED = 3'd5,
    ST_WAIT_BARRIER_OPEN  = 3'd6,
    ST_EMERGENCY          = 3'd7
  } state_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_SHIP_SEEN      = 3'd0,
    REQ_SHIP_GONE      = 3'd1,
    REQ_ROAD_RED       = 3'd2,
    REQ_BARRIER_CLOSED = 3'd3,
    REQ_BRIDGE_OPEN    = 3'd4,
    REQ_BRIDGE_CLOSED  = 3'd5,
    REQ_BARRIER_OPEN   = 3'd6,
    REQ_EMERGENCY      = 3'd7
  } req_e;

  typedef enum logic [TGT_W-1:0] {
    TG_ROAD    = 3'd0,
    TG_BOAT    = 3'd1,
    TG_BARRIER = 3'd2,
    TG_BRIDGE  = 3'd3,
    TG_NONE    = 3'd4
  } target_e;

  typedef enum logic [CODE_W-1:0] {
    CC_RED   = 3'd0,
    CC_GREEN = 3'd1,
    CC_CLOSE = 3'd2,
    CC_OPEN  = 3'd3,
    CC_STOP  = 3'd4,
    CC_RAISE = 3'd5,
    CC_LOWER = 3'd6
  } code_e;

endpackage

@@ rtl/dsc_ram.sv @@
module dsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/drawbridge_sequence_controller_top.sv @@
// An accepted event word is held in the decode stage registers for the memory read;
//   its command list of n words (n = 1..4) then moves to the output buffer registers.
//   No new event is accepted while the decode stage holds a word, and that word leaves
//   only when the output buffer is empty or is sending the last word of its list.
// Reset (async, active low): idle sequence, empty FIFO, max height 0, max width 65535.
//   FIFO memory contents are not cleared; only written entries are ever used.
`include "drawbridge_sequence_controller_top_macros.svh"

module drawbridge_sequence_controller_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // event channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dsc_pkg::REQ_W-1:0]         req_type_i,
  input  logic [dsc_pkg::DIM_W-1:0]         ship_height_i,
  input  logic [dsc_pkg::DIM_W-1:0]         ship_width_i,
  input  logic                              bridge_is_closed_i,
  input  logic                              barrier_is_open_i,
  // command channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsc_pkg::TGT_W-1:0]         command_target_o,
  output logic [dsc_pkg::CODE_W-1:0]        command_code_o,
  output logic [dsc_pkg::ST_W-1:0]          control_state_o,
  output logic [dsc_pkg::CNT_OUT_W-1:0]     queue_count_o,
  output logic                              ship_rejected_o,
  output logic                              queue_overflow_o,
  output logic                              last_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsc_pkg::APB_AW-1:0]        paddr,
  input  logic [dsc_pkg::APB_DW-1:0]        pwdata,
  output logic [dsc_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import dsc_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0] max_height_q, max_width_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_height_q <= '0;
      max_width_q  <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_HEIGHT) begin
        max_height_q <= pwdata[DIM_W-1:0];
      end else begin
        max_width_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_WIDTH) ? APB_DW'(max_width_q) : APB_DW'(max_height_q);

  // ---------------------------------------------------------------
  // Control state
  state_e          seq_q, seq_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   fill_q, fill_d;

  // Decode stage registers (word waits here for the memory read)
  logic            b_valid_q;
  req_e            b_req_q;
  logic            b_sens_ok_q;
  logic            b_rej_q, b_ovf_q;
  logic [CW-1:0]   b_fill_q;
  logic            b_fwd_q, b_fwd_flag_q;

  // Output buffer
  logic            ob_valid_q;
  target_e         ob_tg_q [MAX_CMDS];
  code_e           ob_cc_q [MAX_CMDS];
  logic [1:0]      ob_idx_q, ob_lastidx_q;
  state_e          ob_state_q;
  logic [CW-1:0]   ob_fill_q;
  logic            ob_rej_q, ob_ovf_q;

  logic            in_acc, ob_last, ob_load;

  assign in_ready_o = !b_valid_q;
  assign in_acc     = in_valid_i & in_ready_o;
  assign ob_last    = (ob_idx_q == ob_lastidx_q);
  assign ob_load    = b_valid_q && (!ob_valid_q || (out_ready_i && ob_last));

  // ---------------------------------------------------------------
  // Accept stage: FIFO pointer update, push write, head read
  logic            push, rej_a, ovf_a, flag_a;
  logic [AW:0]     tail_sum;
  logic [AW-1:0]   tail, head_inc;
  logic            ram_flag;
  req_e            req_a;

  assign req_a    = req_e'(req_type_i);
  assign tail_sum = (AW+1)'(head_q) + (AW+1)'(fill_q);
  assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign flag_a   = ship_height_i > max_height_q;

  always_comb begin
    push   = 1'b0;
    rej_a  = 1'b0;
    ovf_a  = 1'b0;
    head_d = head_q;
    fill_d = fill_q;
    if (in_acc) begin
      if (seq_q == ST_EMERGENCY) begin
        if (req_a == REQ_EMERGENCY && bridge_is_closed_i && barrier_is_open_i) begin
          head_d = '0;
          fill_d = '0;
        end
      end else begin
        unique case (req_a)
          REQ_SHIP_SEEN: begin
            if (ship_width_i > max_width_q) begin
              rej_a = 1'b1;
            end else if (fill_q == CW'(QUEUE_DEPTH)) begin
              ovf_a = 1'b1;
            end else begin
              push   = 1'b1;
              fill_d = fill_q + CW'(1);
            end
          end
          REQ_SHIP_GONE: begin
            if (fill_q != '0) begin
              head_d = head_inc;
              fill_d = fill_q - CW'(1);
            end
          end
          REQ_EMERGENCY: begin
            head_d = '0;
            fill_d = '0;
          end
          default: ;
        endcase
      end
    end
  end

  dsc_ram #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail),
    .wdata_i (flag_a),
    .re_i    (in_acc),
    .raddr_i (head_d),
    .rdata_o (ram_flag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (in_acc) begin
        b_valid_q <= 1'b1;
      end else if (ob_load) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the decode stage; push into an empty FIFO bypasses the memory
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_req_q      <= req_a;
      b_sens_ok_q  <= bridge_is_closed_i & barrier_is_open_i;
      b_rej_q      <= rej_a;
      b_ovf_q      <= ovf_a;
      b_fill_q     <= fill_d;
      b_fwd_q      <= push && (fill_q == '0);
      b_fwd_flag_q <= flag_a;
    end
  end

  // ---------------------------------------------------------------
  // Decode stage: sequence step and command list
  target_e         tg_d [MAX_CMDS];
  code_e           cc_d [MAX_CMDS];
  logic [2:0]      n_d;
  logic            lights, head_flag;

  assign head_flag = b_fwd_q ? b_fwd_flag_q : ram_flag;

  always_comb begin
    for (int i = 0; i < MAX_CMDS; i++) begin
      tg_d[i] = TG_NONE;
      cc_d[i] = CC_RED;
    end
    n_d    = '0;
    seq_d  = seq_q;
    lights = 1'b0;
    if (seq_q == ST_EMERGENCY) begin
      if (b_req_q == REQ_EMERGENCY && b_sens_ok_q) begin
        tg_d[n_d[1:0]] = TG_ROAD; cc_d[n_d[1:0]] = CC_GREEN; n_d = n_d + 3'd1;
        tg_d[n_d[1:0]] = TG_BOAT; cc_d[n_d[1:0]] = CC_RED;   n_d = n_d + 3'd1;
        seq_d = ST_IDLE;
      end
    end else begin
      unique case (b_req_q)
        REQ_SHIP_SEEN: lights = !b_rej_q;
        REQ_SHIP_GONE: lights = 1'b1;
        REQ_ROAD_RED: begin
          if (seq_q == ST_WAIT_ROAD_RED) begin
            tg_d[n_d[1:0]] = TG_BARRIER; cc_d[n_d[1:0]] = CC_CLOSE; n_d = n_d + 3'd1;
            seq_d = ST_WAIT_BARRIER_CLOSED;
          end
        end
        REQ_BARRIER_CLOSED: begin
          if (seq_q == ST_WAIT_BARRIER_CLOSED) begin
            tg_d[n_d[1:0]] = TG_BRIDGE; cc_d[n_d[1:0]] = CC_RAISE; n_d = n_d + 3'd1;
            seq_d = ST_WAIT_BRIDGE_OPEN;
          end
        end
        REQ_BRIDGE_OPEN: begin
          if (seq_q == ST_WAIT_BRIDGE_OPEN) begin
            tg_d[n_d[1:0]] = TG_BOAT; cc_d[n_d[1:0]] = CC_GREEN; n_d = n_d + 3'd1;
            seq_d = ST_OPEN;
          end
        end
        REQ_BRIDGE_CLOSED: begin
          if (seq_q == ST_WAIT_BRIDGE_CLOSED) begin
            tg_d[n_d[1:0]] = TG_BARRIER; cc_d[n_d[1:0]] = CC_OPEN; n_d = n_d + 3'd1;
            seq_d = ST_WAIT_BARRIER_OPEN;
          end
        end
        REQ_BARRIER_OPEN: begin
          if (seq_q == ST_WAIT_BARRIER_OPEN) begin
            tg_d[n_d[1:0]] = TG_ROAD; cc_d[n_d[1:0]] = CC_GREEN; n_d = n_d + 3'd1;
            seq_d  = ST_IDLE;
            lights = 1'b1;
          end
        end
        REQ_EMERGENCY: begin
          tg_d[0] = TG_BRIDGE;  cc_d[0] = CC_STOP;
          tg_d[1] = TG_BARRIER; cc_d[1] = CC_STOP;
          tg_d[2] = TG_ROAD;    cc_d[2] = CC_RED;
          tg_d[3] = TG_BOAT;    cc_d[3] = CC_RED;
          n_d   = 3'd4;
          seq_d = ST_EMERGENCY;
        end
        default: ;
      endcase
    end

    // Boat light update on the queue as it stands after this word
    if (lights) begin
      if (b_fill_q == '0) begin
        if (seq_d == ST_OPEN) begin
          tg_d[n_d[1:0]] = TG_BOAT;   cc_d[n_d[1:0]] = CC_RED;   n_d = n_d + 3'd1;
          tg_d[n_d[1:0]] = TG_BRIDGE; cc_d[n_d[1:0]] = CC_LOWER; n_d = n_d + 3'd1;
          seq_d = ST_WAIT_BRIDGE_CLOSED;
        end
        tg_d[n_d[1:0]] = TG_BOAT; cc_d[n_d[1:0]] = CC_RED; n_d = n_d + 3'd1;
      end else if (!head_flag) begin
        tg_d[n_d[1:0]] = TG_BOAT; cc_d[n_d[1:0]] = CC_GREEN; n_d = n_d + 3'd1;
      end else begin
        tg_d[n_d[1:0]] = TG_BOAT; cc_d[n_d[1:0]] = CC_RED; n_d = n_d + 3'd1;
        if (seq_d == ST_IDLE) begin
          tg_d[n_d[1:0]] = TG_ROAD; cc_d[n_d[1:0]] = CC_RED; n_d = n_d + 3'd1;
          seq_d = ST_WAIT_ROAD_RED;
        end
      end
    end
  end

  // Sequence state commits when the command list moves to the output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= ST_IDLE;
    end else if (ob_load) begin
      seq_q <= seq_d;
    end
  end

  // ---------------------------------------------------------------
  // Output buffer, one command word per cycle while out_ready_i is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_idx_q   <= '0;
    end else if (ob_load) begin
      ob_valid_q <= 1'b1;
      ob_idx_q   <= '0;
    end else if (ob_valid_q && out_ready_i) begin
      if (ob_last) begin
        ob_valid_q <= 1'b0;
      end else begin
        ob_idx_q <= ob_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_load) begin
      for (int i = 0; i < MAX_CMDS; i++) begin
        ob_tg_q[i] <= tg_d[i];
        ob_cc_q[i] <= cc_d[i];
      end
      ob_lastidx_q <= (n_d == '0) ? 2'd0 : 2'(n_d - 3'd1);
      ob_state_q   <= seq_d;
      ob_fill_q    <= b_fill_q;
      ob_rej_q     <= b_rej_q;
      ob_ovf_q     <= b_ovf_q;
    end
  end

  logic [CW+CNT_OUT_W-1:0] qcnt_ext;
  assign qcnt_ext = (CW+CNT_OUT_W)'(ob_fill_q);

  assign out_valid_o      = ob_valid_q;
  assign command_target_o = ob_tg_q[ob_idx_q];
  assign command_code_o   = ob_cc_q[ob_idx_q];
  assign control_state_o  = ob_state_q;
  assign queue_count_o    = qcnt_ext[CNT_OUT_W-1:0];
  assign ship_rejected_o  = ob_rej_q;
  assign queue_overflow_o = ob_ovf_q;
  assign last_o           = ob_last;

  // ---------------------------------------------------------------
  // Checks
  `DSC_ASSERT(a_fill_bound, fill_q <= CW'(QUEUE_DEPTH), "FIFO fill above depth")
  `DSC_ASSERT(a_emerg_empty, (seq_q != ST_EMERGENCY) || (fill_q == '0),
              "FIFO not empty in emergency")
  `DSC_ASSERT(a_ob_idx, !ob_valid_q || (ob_idx_q <= ob_lastidx_q),
              "output index beyond command list")
  `DSC_ASSERT_NEXT(a_acc_decode, in_acc, b_valid_q && !in_ready_o,
                   "accepted word not held in decode stage")

endmodule

@@ tb/tb_drawbridge_sequence_controller_top.sv @@
`timescale 1ns / 100ps

module tb_drawbridge_sequence_controller_top;
  import dsc_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [APB_AW-1:0] ADDR_MAX_HEIGHT = {REG_MAX_HEIGHT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MAX_WIDTH  = {REG_MAX_WIDTH, 2'b00};
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    req_e             req;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic             bridge_closed;
    logic             barrier_open;
  } ship_event_t;

  typedef struct packed {
    target_e              tg;
    code_e                cc;
    state_e               st;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 rej;
    logic                 ovf;
    logic                 last;
  } cmd_word_t;

  // rep of zero: no event, height and width are loaded into the limit registers
  typedef struct packed {
    ship_event_t ev;
    logic [5:0]  rep;
    logic        pin;
    cmd_word_t   want;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [DIM_W-1:0]     ship_height_i;
  logic [DIM_W-1:0]     ship_width_i;
  logic                 bridge_is_closed_i;
  logic                 barrier_is_open_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [TGT_W-1:0]     command_target_o;
  logic [CODE_W-1:0]    command_code_o;
  logic [ST_W-1:0]      control_state_o;
  logic [CNT_OUT_W-1:0] queue_count_o;
  logic                 ship_rejected_o;
  logic                 queue_overflow_o;
  logic                 last_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // predictor state
  state_e           pred_state;
  logic             ship_tall [QDEPTH];
  logic [3:0]       fifo_head_q;
  logic [4:0]       fifo_fill_q;
  logic [DIM_W-1:0] lim_height;
  logic [DIM_W-1:0] lim_width;
  cmd_word_t        step_words[$];
  cmd_word_t        expected_cmds[$];
  script_row_t      script_rows[$];

  int   mismatches = 0;
  int   words_seen = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  drawbridge_sequence_controller_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .ship_height_i     (ship_height_i),
    .ship_width_i      (ship_width_i),
    .bridge_is_closed_i(bridge_is_closed_i),
    .barrier_is_open_i (barrier_is_open_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .command_target_o  (command_target_o),
    .command_code_o    (command_code_o),
    .control_state_o   (control_state_o),
    .queue_count_o     (queue_count_o),
    .ship_rejected_o   (ship_rejected_o),
    .queue_overflow_o  (queue_overflow_o),
    .last_o            (last_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------

  function automatic void add_cmd(target_e tg, code_e cc);
    cmd_word_t w;
    if (step_words.size() < MAX_CMDS) begin
      w = '0;
      w.tg = tg;
      w.cc = cc;
      step_words = {step_words, w};
    end
  endfunction

  // boat light follows the ship at the head of the queue; a tall one starts the opening from idle
  function automatic void refresh_boat_light();
    if (fifo_fill_q == 0) begin
      if (pred_state == ST_OPEN) begin
        add_cmd(TG_BOAT, CC_RED);
        add_cmd(TG_BRIDGE, CC_LOWER);
        pred_state = ST_WAIT_BRIDGE_CLOSED;
      end
      add_cmd(TG_BOAT, CC_RED);
    end else if (!ship_tall[fifo_head_q]) begin
      add_cmd(TG_BOAT, CC_GREEN);
    end else begin
      add_cmd(TG_BOAT, CC_RED);
      if (pred_state == ST_IDLE) begin
        add_cmd(TG_ROAD, CC_RED);
        pred_state = ST_WAIT_ROAD_RED;
      end
    end
  endfunction

  function automatic void predict_commands(ship_event_t ev);
    logic      rej;
    logic      ovf;
    cmd_word_t w;
    rej = 1'b0;
    ovf = 1'b0;
    step_words.delete();
    if (pred_state == ST_EMERGENCY) begin
      // only a second emergency with the deck down and barrier up releases
      if (ev.req == REQ_EMERGENCY && ev.bridge_closed && ev.barrier_open) begin
        add_cmd(TG_ROAD, CC_GREEN);
        add_cmd(TG_BOAT, CC_RED);
        fifo_head_q = '0;
        fifo_fill_q = '0;
        pred_state  = ST_IDLE;
      end
    end else begin
      case (ev.req)
        REQ_SHIP_SEEN: begin
          if (ev.width > lim_width) begin
            rej = 1'b1;
          end else begin
            if (fifo_fill_q >= QDEPTH) begin
              ovf = 1'b1;
            end else begin
              ship_tall[4'(fifo_head_q + fifo_fill_q)] = ev.height > lim_height;
              fifo_fill_q = fifo_fill_q + 1'b1;
            end
            refresh_boat_light();
          end
        end
        REQ_SHIP_GONE: begin
          if (fifo_fill_q != 0) begin
            fifo_head_q = fifo_head_q + 1'b1;
            fifo_fill_q = fifo_fill_q - 1'b1;
          end
          refresh_boat_light();
        end
        REQ_ROAD_RED: begin
          if (pred_state == ST_WAIT_ROAD_RED) begin
            add_cmd(TG_BARRIER, CC_CLOSE);
            pred_state = ST_WAIT_BARRIER_CLOSED;
          end
        end
        REQ_BARRIER_CLOSED: begin
          if (pred_state == ST_WAIT_BARRIER_CLOSED) begin
            add_cmd(TG_BRIDGE, CC_RAISE);
            pred_state = ST_WAIT_BRIDGE_OPEN;
          end
        end
        REQ_BRIDGE_OPEN: begin
          if (pred_state == ST_WAIT_BRIDGE_OPEN) begin
            add_cmd(TG_BOAT, CC_GREEN);
            pred_state = ST_OPEN;
          end
        end
        REQ_BRIDGE_CLOSED: begin
          if (pred_state == ST_WAIT_BRIDGE_CLOSED) begin
            add_cmd(TG_BARRIER, CC_OPEN);
            pred_state = ST_WAIT_BARRIER_OPEN;
          end
        end
        REQ_BARRIER_OPEN: begin
          if (pred_state == ST_WAIT_BARRIER_OPEN) begin
            add_cmd(TG_ROAD, CC_GREEN);
            pred_state = ST_IDLE;
            refresh_boat_light();
          end
        end
        default: begin
          add_cmd(TG_BRIDGE, CC_STOP);
          add_cmd(TG_BARRIER, CC_STOP);
          add_cmd(TG_ROAD, CC_RED);
          add_cmd(TG_BOAT, CC_RED);
          fifo_head_q = '0;
          fifo_fill_q = '0;
          pred_state  = ST_EMERGENCY;
        end
      endcase
    end

    // an event with no command still yields one word
    if (step_words.size() == 0) add_cmd(TG_NONE, CC_RED);
    foreach (step_words[k]) begin
      w      = step_words[k];
      w.st   = pred_state;
      w.cnt  = fifo_fill_q;
      w.rej  = rej;
      w.ovf  = ovf;
      w.last = (k == step_words.size() - 1);
      expected_cmds = {expected_cmds, w};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random event source, biased towards the acknowledgement the sequence waits for
  // ---------------------------------------------------------------------------

  function automatic logic [DIM_W-1:0] pick_height();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return lim_height;
      3:       return 16'(lim_height + 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_width();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      2:       return lim_width;
      3:       return 16'(lim_width + 1);
      default: return 16'($urandom_range(lim_width));
    endcase
  endfunction

  function automatic ship_event_t next_event();
    ship_event_t ev;
    ev.height        = pick_height();
    ev.width         = pick_width();
    ev.bridge_closed = 1'($urandom_range(1));
    ev.barrier_open  = 1'($urandom_range(1));
    // some noise: any event at any time
    if ($urandom_range(99) < 22) begin
      ev.req = req_e'($urandom_range(7));
      return ev;
    end
    case (pred_state)
      ST_IDLE: begin
        ev.req = (fifo_fill_q != 0 && $urandom_range(99) < 55) ? REQ_SHIP_GONE : REQ_SHIP_SEEN;
      end
      ST_WAIT_ROAD_RED:       ev.req = REQ_ROAD_RED;
      ST_WAIT_BARRIER_CLOSED: ev.req = REQ_BARRIER_CLOSED;
      ST_WAIT_BRIDGE_OPEN:    ev.req = REQ_BRIDGE_OPEN;
      ST_OPEN: begin
        ev.req = ($urandom_range(99) < 70) ? REQ_SHIP_GONE : REQ_SHIP_SEEN;
      end
      ST_WAIT_BRIDGE_CLOSED:  ev.req = REQ_BRIDGE_CLOSED;
      ST_WAIT_BARRIER_OPEN:   ev.req = REQ_BARRIER_OPEN;
      default: begin
        ev.req = REQ_EMERGENCY;
        if ($urandom_range(3) != 0) begin
          ev.bridge_closed = 1'b1;
          ev.barrier_open  = 1'b1;
        end
      end
    endcase
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Event channel
  // ---------------------------------------------------------------------------

  task automatic sender_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_event(ship_event_t ev);
    in_valid_i         <= 1'b1;
    req_type_i         <= ev.req;
    ship_height_i      <= ev.height;
    ship_width_i       <= ev.width;
    bridge_is_closed_i <= ev.bridge_closed;
    barrier_is_open_i  <= ev.barrier_open;
    do @(posedge clk_i); while (!in_ready_o);
    predict_commands(ev);
  endtask

  // stop offering and wait for every outstanding command word
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      sender_gap();
      send_event(next_event());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // upper bits are not part of the 16-bit limits
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      value = prdata[DIM_W-1:0];
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_limits();
    logic [DIM_W-1:0] rd;
    apb_read(ADDR_MAX_HEIGHT, rd);
    if (rd !== lim_height)
      report_mismatch($sformatf("max_ship_height read %0d, expected %0d", rd, lim_height));
    apb_read(ADDR_MAX_WIDTH, rd);
    if (rd !== lim_width)
      report_mismatch($sformatf("max_ship_width read %0d, expected %0d", rd, lim_width));
  endtask

  task automatic set_limits(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w);
    apb_write(ADDR_MAX_HEIGHT, h);
    apb_write(ADDR_MAX_WIDTH, w);
    lim_height = h;
    lim_width  = w;
    check_limits();
  endtask

  // ---------------------------------------------------------------------------
  // Command channel: ready pattern, long hold-off and word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                words_seen, name, got, want));
  endtask

  always @(posedge clk_i) begin : cmd_monitor
    cmd_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        want = expected_cmds[0];
        expected_cmds.delete(0);
        check_field("command_target", command_target_o, want.tg);
        check_field("command_code", command_code_o, want.cc);
        check_field("control_state", control_state_o, want.st);
        check_field("queue_count", queue_count_o, want.cnt);
        check_field("ship_rejected", ship_rejected_o, want.rej);
        check_field("queue_overflow", queue_overflow_o, want.ovf);
        check_field("last", last_o, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script rows
  // ---------------------------------------------------------------------------

  function automatic script_row_t row(req_e req, int h, int w, bit bc, bit bo, int rep = 1,
                                      bit pin = 0, target_e tg = TG_NONE,
                                      code_e cc = CC_RED, state_e st = ST_IDLE,
                                      int cnt = 0, bit rej = 0, bit ovf = 0);
    script_row_t r;
    r.ev.req           = req;
    r.ev.height        = 16'(h);
    r.ev.width         = 16'(w);
    r.ev.bridge_closed = bc;
    r.ev.barrier_open  = bo;
    r.rep              = 6'(rep);
    r.pin              = pin;
    r.want.tg          = tg;
    r.want.cc          = cc;
    r.want.st          = st;
    r.want.cnt         = 5'(cnt);
    r.want.rej         = rej;
    r.want.ovf         = ovf;
    r.want.last        = 1'b1;
    return r;
  endfunction

  function automatic void add_row(script_row_t r);
    script_rows = {script_rows, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    script_row_t r;

    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    req_type_i         <= REQ_SHIP_SEEN;
    ship_height_i      <= '0;
    ship_width_i       <= '0;
    bridge_is_closed_i <= 1'b0;
    barrier_is_open_i  <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    pred_state  = ST_IDLE;
    fifo_head_q = '0;
    fifo_fill_q = '0;
    lim_height  = '0;
    lim_width   = '1;
    foreach (ship_tall[i]) ship_tall[i] = 1'b0;

    // idle, empty queue: ship gone just sets the boat light red
    add_row(row(REQ_SHIP_GONE, 0, 0, 0, 0, 1, 1, TG_BOAT, CC_RED, ST_IDLE, 0));
    // acknowledgement out of sequence: no command
    add_row(row(REQ_ROAD_RED, 0, 0, 1, 1, 1, 1, TG_NONE, CC_RED, ST_IDLE, 0));
    // widest ship at reset limits, not taller than height 0
    add_row(row(REQ_SHIP_SEEN, 0, 65535, 0, 0, 1, 1, TG_BOAT, CC_GREEN, ST_IDLE, 1));
    // tallest ship queued behind a low one
    add_row(row(REQ_SHIP_SEEN, 65535, 0, 1, 0, 1, 1, TG_BOAT, CC_GREEN, ST_IDLE, 2));
    // low ship leaves, tall one at head: full open and close sequence
    add_row(row(REQ_SHIP_GONE, 0, 0, 0, 1));
    add_row(row(REQ_ROAD_RED, 0, 0, 0, 0));
    add_row(row(REQ_BARRIER_CLOSED, 0, 0, 0, 0));
    add_row(row(REQ_BRIDGE_OPEN, 0, 0, 0, 0));
    add_row(row(REQ_SHIP_GONE, 0, 0, 0, 0));
    add_row(row(REQ_BRIDGE_CLOSED, 0, 0, 1, 0));
    add_row(row(REQ_BARRIER_OPEN, 0, 0, 1, 1));
    // emergency, ignored events and refused releases
    add_row(row(REQ_EMERGENCY, 0, 0, 0, 0));
    add_row(row(REQ_SHIP_SEEN, 65535, 0, 1, 1, 1, 1, TG_NONE, CC_RED, ST_EMERGENCY, 0));
    add_row(row(REQ_EMERGENCY, 0, 0, 1, 0, 1, 1, TG_NONE, CC_RED, ST_EMERGENCY, 0));
    add_row(row(REQ_EMERGENCY, 0, 0, 0, 1, 1, 1, TG_NONE, CC_RED, ST_EMERGENCY, 0));
    add_row(row(REQ_EMERGENCY, 0, 0, 1, 1));
    // tighter limits: height 50, width 100
    add_row(row(REQ_SHIP_SEEN, 50, 100, 0, 0, 0));
    add_row(row(REQ_SHIP_SEEN, 0, 101, 0, 0, 1, 1, TG_NONE, CC_RED, ST_IDLE, 0, 1));
    add_row(row(REQ_SHIP_SEEN, 51, 100, 0, 0));
    // fill the queue, then one more is dropped
    add_row(row(REQ_SHIP_SEEN, 50, 100, 0, 0, 15));
    add_row(row(REQ_SHIP_SEEN, 65535, 0, 0, 0, 1, 1, TG_BOAT, CC_RED,
                ST_WAIT_ROAD_RED, 16, 0, 1));
    add_row(row(REQ_EMERGENCY, 0, 0, 0, 0));
    add_row(row(REQ_EMERGENCY, 0, 0, 1, 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limits();

    // directed script
    tx_idle_pct = 11;
    rx_idle_pct = 55;
    foreach (script_rows[i]) begin
      r = script_rows[i];
      if (r.rep == 0) begin
        settle();
        set_limits(r.ev.height, r.ev.width);
      end else begin
        repeat (r.rep) begin
          sender_gap();
          send_event(r.ev);
          if (r.pin) expected_cmds[expected_cmds.size() - 1] = r.want;
        end
      end
    end

    // random phases: sender idles lightly, then receiver lightly, then neither
    settle();
    set_limits(16'($urandom), 16'($urandom_range(65535, 30000)));
    run_random(50, 11, 55);

    settle();
    set_limits('1, '1);
    run_random(50, 55, 11);

    settle();
    set_limits('0, '0);
    run_random(30, 0, 0);

    // receiver holds off for a long stretch while events keep coming
    settle();
    set_limits(16'($urandom), 16'($urandom_range(65535, 20000)));
    hold_go = 1'b1;
    run_random(64, 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
